### hw/rtl/afb_pkg.sv
// Shared types, constants and knot tables for the activation forward/backward unit.
// No dependencies; imported by the top level, by afb_seg_lookup and by the testbench.
`timescale 1ns / 1ps

package afb_pkg;

	// Fixed-point format of every data field (signed Q4.12).
	localparam int FRAC_BITS = 12;
	localparam int DATA_BITS = 16;

	// Piecewise-linear table: equal segments spanning the whole 16-bit input range.
	localparam int SEGMENTS      = 32;
	localparam int SEG_BITS      = $clog2(SEGMENTS);
	localparam int OFF_BITS      = DATA_BITS - SEG_BITS;
	localparam int KNOT_IDX_BITS = SEG_BITS + 1;

	// Unity in Q4.12 and in the squared (Q24) derivative scale.
	localparam int ONE_Q     = 1 << FRAC_BITS;
	localparam int DERIV_ONE = 1 << (2 * FRAC_BITS);

	localparam int ACT_MODE_BITS = 2;

	typedef enum logic [ACT_MODE_BITS-1:0] {
		MODE_RELU     = 2'd0,
		MODE_SIGMOID  = 2'd1,
		MODE_TANH     = 2'd2,
		MODE_IDENTITY = 2'd3
	} act_mode_t;

	localparam logic ACTION_FORWARD  = 1'b0;
	localparam logic ACTION_BACKWARD = 1'b1;

	// One segment of the curve: left knot, rise to the right knot, offset inside.
	typedef struct packed {
		logic signed [DATA_BITS-1:0] base;
		logic signed [DATA_BITS-1:0] delta;
		logic [OFF_BITS-1:0]         offset;
	} pwl_seg_t;

	// Knot values in Q4.12, knot k at x = -8 + 16k/SEGMENTS.
	localparam logic signed [DATA_BITS-1:0] SIG_KNOT [0:SEGMENTS] = '{
		16'sd1,    16'sd2,    16'sd4,    16'sd6,    16'sd10,   16'sd17,   16'sd27,
		16'sd45,   16'sd74,   16'sd120,  16'sd194,  16'sd311,  16'sd488,  16'sd747,
		16'sd1102, 16'sd1546, 16'sd2048, 16'sd2550, 16'sd2994, 16'sd3349, 16'sd3608,
		16'sd3785, 16'sd3902, 16'sd3976, 16'sd4022, 16'sd4051, 16'sd4069, 16'sd4079,
		16'sd4086, 16'sd4090, 16'sd4092, 16'sd4094, 16'sd4095
	};

	localparam logic signed [DATA_BITS-1:0] TANH_KNOT [0:SEGMENTS] = '{
		-16'sd4096, -16'sd4096, -16'sd4096, -16'sd4096, -16'sd4096, -16'sd4096,
		-16'sd4096, -16'sd4095, -16'sd4093, -16'sd4089, -16'sd4076, -16'sd4041,
		-16'sd3949, -16'sd3707, -16'sd3119, -16'sd1893, 16'sd0,     16'sd1893,
		16'sd3119,  16'sd3707,  16'sd3949,  16'sd4041,  16'sd4076,  16'sd4089,
		16'sd4093,  16'sd4095,  16'sd4096,  16'sd4096,  16'sd4096,  16'sd4096,
		16'sd4096,  16'sd4096,  16'sd4096
	};

endpackage

### hw/rtl/activation_forward_backward_unit.sv
// Top level of the activation forward/backward unit: four-stage pipeline.
// Depends on afb_pkg and afb_seg_lookup.
//
// Usage
//   cfg channel: write act_mode (0 relu, 1 sigmoid, 2 tanh, 3 identity) while the
//   block is idle; cfg_ready is always high, so a write lands on the edge of cfg_valid.
//   s_* stream: one element per transaction. tuser selects forward (0) or backward (1),
//   tlast marks the final element of a tensor and is copied to m_tlast.
//   m_* stream: one result per input transaction, in order.
// Pipeline and throughput
//   The accepting edge loads stage 1; the element then moves through stages 2, 3 and 4,
//   and m_tvalid rises once stage 4 holds it. A stall can hold it in any stage.
//   One element per cycle sustained while m_tready stays high. The four register stages:
//   table read / derivative multiply, interpolation / gradient multiply, rounding,
//   accumulate and saturate.
// Reset and stall
//   arst_n clears every valid bit and sets act_mode to relu. When the receiver holds
//   m_tready low the result stays on m_* unchanged; earlier stages keep filling
//   any empty slot, so s_tready drops only once all four stages are occupied.
module activation_forward_backward_unit
	import afb_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,

	input  logic                     cfg_valid,
	output logic                     cfg_ready,
	input  logic [ACT_MODE_BITS-1:0] cfg_data,    // act_mode

	input  logic                     s_tvalid,
	output logic                     s_tready,
	// [15:0] x_value, [31:16] y_value, [47:32] upstream_grad, [63:48] accumulated_grad
	input  logic [63:0]              s_tdata,
	input  logic [0:0]               s_tuser,     // [0] action
	input  logic                     s_tlast,

	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [15:0]              m_tdata,     // [15:0] result_value
	output logic                     m_tlast
);

	act_mode_t act_mode_q;

	// Configuration: take every write, keep the low two bits.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_mode_q <= MODE_RELU;
		end else if (cfg_valid && cfg_ready) begin
			act_mode_q <= act_mode_t'(cfg_data);
		end
	end

	// Input unpacking
	logic signed [DATA_BITS-1:0] x_in, y_in, up_in, acc_in;

	assign x_in   = $signed(s_tdata[15:0]);
	assign y_in   = $signed(s_tdata[31:16]);
	assign up_in  = $signed(s_tdata[47:32]);
	assign acc_in = $signed(s_tdata[63:48]);

	// Per-stage flow control: a stage may load when it is empty or its
	// successor is loading.
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv_s1, adv_s2, adv_s3, adv_s4;

	assign adv_s4   = !valid_s4 || m_tready;
	assign adv_s3   = !valid_s3 || adv_s4;
	assign adv_s2   = !valid_s2 || adv_s3;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign s_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= s_tvalid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
		end
	end

	// Stage 1: knot read for the forward curve, derivative in Q24 for backward.
	pwl_seg_t seg_in;

	afb_seg_lookup u_seg_lookup (
		.mode (act_mode_q),
		.x    (x_in),
		.seg  (seg_in)
	);

	logic signed [DATA_BITS:0]   deriv_opnd;
	logic signed [32:0]          deriv_prod;
	logic signed [31:0]          deriv_in;
	logic                        x_pos_in;

	assign x_pos_in = !x_in[DATA_BITS-1] && (|x_in);

	always_comb begin
		// sigmoid: y * (1 - y); tanh: 1 - y * y, both in Q24
		deriv_opnd = (act_mode_q == MODE_SIGMOID) ?
			(($signed((DATA_BITS+1)'(ONE_Q))) - (DATA_BITS+1)'(y_in)) :
			(DATA_BITS+1)'(y_in);
		deriv_prod = 33'(y_in) * 33'(deriv_opnd);
		unique case (act_mode_q)
			MODE_RELU:     deriv_in = x_pos_in ? 32'(DERIV_ONE) : 32'sd0;
			MODE_SIGMOID:  deriv_in = deriv_prod[31:0];
			MODE_TANH:     deriv_in = 32'(DERIV_ONE) - deriv_prod[31:0];
			MODE_IDENTITY: deriv_in = 32'(DERIV_ONE);
			default:       deriv_in = 32'(DERIV_ONE);
		endcase
	end

	logic                        back_s1, last_s1;
	logic signed [DATA_BITS-1:0] x_s1, up_s1, acc_s1;
	pwl_seg_t                    seg_s1;
	logic signed [31:0]          deriv_s1;

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			back_s1  <= (s_tuser[0] == ACTION_BACKWARD);
			last_s1  <= s_tlast;
			x_s1     <= x_in;
			up_s1    <= up_in;
			acc_s1   <= acc_in;
			seg_s1   <= seg_in;
			deriv_s1 <= deriv_in;
		end
	end

	// Stage 2: interpolation numerator and gradient product.
	logic signed [27:0] interp_comb;
	logic signed [47:0] grad_comb;

	assign interp_comb = (28'(seg_s1.base) <<< OFF_BITS)
		+ 28'(seg_s1.delta) * 28'($signed({1'b0, seg_s1.offset}));
	assign grad_comb   = 48'(up_s1) * 48'(deriv_s1);

	logic                        back_s2, last_s2;
	logic signed [DATA_BITS-1:0] x_s2, acc_s2;
	logic signed [27:0]          interp_s2;
	logic signed [47:0]          grad_s2;

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			back_s2   <= back_s1;
			last_s2   <= last_s1;
			x_s2      <= x_s1;
			acc_s2    <= acc_s1;
			interp_s2 <= interp_comb;
			grad_s2   <= grad_comb;
		end
	end

	// Stage 3: round both products to nearest, halves away from zero; pick the
	// forward result for the mode.
	logic [27:0]                 interp_mag;
	logic [27:0]                 interp_rnd;
	logic signed [DATA_BITS-1:0] curve_val;
	logic [47:0]                 grad_mag;
	logic [47:0]                 grad_rnd;
	logic signed [24:0]          term_comb;
	logic signed [DATA_BITS-1:0] fwd_comb;

	always_comb begin
		interp_mag = interp_s2[27] ? 28'(-interp_s2) : 28'(interp_s2);
		interp_rnd = (interp_mag + 28'(1 << (OFF_BITS - 1))) >> OFF_BITS;
		curve_val  = interp_s2[27] ? -$signed(interp_rnd[DATA_BITS-1:0])
		                           : $signed(interp_rnd[DATA_BITS-1:0]);

		grad_mag  = grad_s2[47] ? 48'(-grad_s2) : 48'(grad_s2);
		grad_rnd  = (grad_mag + 48'(1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS);
		term_comb = grad_s2[47] ? -$signed(grad_rnd[24:0]) : $signed(grad_rnd[24:0]);

		unique case (act_mode_q)
			MODE_RELU:     fwd_comb = (!x_s2[DATA_BITS-1] && (|x_s2)) ? x_s2 : '0;
			MODE_SIGMOID:  fwd_comb = curve_val;
			MODE_TANH:     fwd_comb = curve_val;
			MODE_IDENTITY: fwd_comb = x_s2;
			default:       fwd_comb = x_s2;
		endcase
	end

	logic                        back_s3, last_s3;
	logic signed [DATA_BITS-1:0] acc_s3, fwd_s3;
	logic signed [24:0]          term_s3;

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			back_s3 <= back_s2;
			last_s3 <= last_s2;
			acc_s3  <= acc_s2;
			fwd_s3  <= fwd_comb;
			term_s3 <= term_comb;
		end
	end

	// Stage 4: accumulate, saturate to 16 bits, drive the output register.
	logic signed [25:0]          sum_comb;
	logic signed [DATA_BITS-1:0] sat_comb;

	always_comb begin
		sum_comb = 26'(acc_s3) + 26'(term_s3);
		priority if (sum_comb > 26'sd32767) begin
			sat_comb = 16'sh7FFF;
		end else if (sum_comb < -26'sd32768) begin
			sat_comb = -16'sh8000;
		end else begin
			sat_comb = sum_comb[DATA_BITS-1:0];
		end
	end

	logic signed [DATA_BITS-1:0] result_s4;
	logic                        last_s4;

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			result_s4 <= back_s3 ? sat_comb : fwd_s3;
			last_s4   <= last_s3;
		end
	end

	assign m_tvalid = valid_s4;
	assign m_tdata  = result_s4;
	assign m_tlast  = last_s4;

endmodule

### hw/rtl/afb_seg_lookup.sv
// Segment lookup for the sigmoid and tanh curves: picks the two knots around x.
// Depends on afb_pkg (knot tables, pwl_seg_t).
`timescale 1ns / 1ps

module afb_seg_lookup
	import afb_pkg::*;
(
	input  act_mode_t                   mode,
	input  logic signed [DATA_BITS-1:0] x,
	output pwl_seg_t                    seg
);

	logic [KNOT_IDX_BITS-1:0]    idx;
	logic [KNOT_IDX_BITS-1:0]    idx_next;
	logic signed [DATA_BITS-1:0] knot_lo;
	logic signed [DATA_BITS-1:0] knot_hi;

	// Offset-binary view of x: the top bits count segments from -8.
	assign idx      = {1'b0, ~x[DATA_BITS-1], x[DATA_BITS-2:OFF_BITS]};
	assign idx_next = idx + KNOT_IDX_BITS'(1);

	always_comb begin
		if (mode == MODE_TANH) begin
			knot_lo = TANH_KNOT[idx];
			knot_hi = TANH_KNOT[idx_next];
		end else begin
			knot_lo = SIG_KNOT[idx];
			knot_hi = SIG_KNOT[idx_next];
		end
	end

	assign seg.base   = knot_lo;
	assign seg.delta  = knot_hi - knot_lo;
	assign seg.offset = x[OFF_BITS-1:0];

endmodule

### hw/rtl/afb_checker.sv
// Port-level checker for the activation forward/backward unit, bound to the top level.
// Depends only on the top-level ports.
`timescale 1ns / 1ps

module afb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// A stalled result stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// With nothing offered at the output, the pipeline cannot be full.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

	// An accepted element reaches the output when m_tready stays high while it crosses the stages.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && m_tready) ##1 m_tready ##1 m_tready ##1 m_tready
		|=> m_tvalid)
		else $error("result missing after pipeline latency");

endmodule

bind activation_forward_backward_unit afb_checker u_afb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast)
);

### tb/sv/tb_activation_forward_backward_unit.sv
// Self-checking testbench for activation_forward_backward_unit: ReLU, sigmoid, tanh and identity,
// forward and backward, under random source gaps and sink back-pressure.
// Depends on afb_pkg and the RTL of the block; needs no files or arguments.
`timescale 1ns / 1ps

module tb_activation_forward_backward_unit;
	import afb_pkg::*;

	localparam int PIPE_LATENCY   = 4;
	localparam int RANDOM_PER_SET = 134;        // 3 idling profiles x 4 modes x 134
	localparam int DIRECTED_COUNT = 23;
	localparam int TIMEOUT_NS     = 2_000_000;
	localparam int PRINT_LIMIT    = 100;
	localparam int SEG_SPAN       = (16 << FRAC_BITS) / SEGMENTS;
	localparam int Q_ONE          = 1 << FRAC_BITS;
	localparam longint unsigned Q30 = 64'd1 << 30;

	// One input element, one result, one row of the directed table
	typedef struct packed {
		logic                        action;
		logic signed [DATA_BITS-1:0] x;
		logic signed [DATA_BITS-1:0] y;
		logic signed [DATA_BITS-1:0] up;
		logic signed [DATA_BITS-1:0] acc;
		logic                        last;
	} element_t;

	typedef struct packed {
		logic signed [DATA_BITS-1:0] value;
		logic                        last;
	} grad_result_t;

	typedef struct packed {
		act_mode_t                   mode;
		logic                        action;
		logic signed [DATA_BITS-1:0] x;
		logic signed [DATA_BITS-1:0] y;
		logic signed [DATA_BITS-1:0] up;
		logic signed [DATA_BITS-1:0] acc;
		logic                        last;
		logic                        typed;     // value below was worked out by hand
		logic signed [DATA_BITS-1:0] value;
	} directed_row_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     cfg_valid;
	logic                     cfg_ready;
	logic [ACT_MODE_BITS-1:0] cfg_data;
	logic                     s_tvalid;
	logic                     s_tready;
	// [15:0] x_value, [31:16] y_value, [47:32] upstream_grad, [63:48] accumulated_grad
	logic [63:0]              s_tdata;
	logic [0:0]               s_tuser;      // [0] action
	logic                     s_tlast;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [15:0]              m_tdata;      // [15:0] result_value
	logic                     m_tlast;

	// Own copy of the curve knots, built from first principles at time zero
	longint       sig_knots  [SEGMENTS+1];
	longint       tanh_knots [SEGMENTS+1];
	act_mode_t    current_mode;
	grad_result_t expected_results [$];
	int unsigned  sender_idle_pct;
	int unsigned  receiver_stall_pct;
	int           error_count;
	int           checked_count;
	int           mode_items [4];
	directed_row_t directed_rows [DIRECTED_COUNT];

	activation_forward_backward_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Knot generation: e^-u by a truncated series in Q30, then sigma and tanh
	// ------------------------------------------------------------------

	// e^f for f in [0, 1], Q30 in and out
	function automatic longint unsigned exp_series(input longint unsigned f);
		longint unsigned term;
		longint unsigned sum;
		term = Q30;
		sum  = Q30;
		for (int k = 1; k <= 24; k++) begin
			term = ((term * f) >> 30) / 64'(k);
			sum += term;
		end
		return sum;
	endfunction

	// e^-u for u >= 0: fractional part by series, whole part by repeated e^-1
	function automatic longint unsigned exp_decay(input longint unsigned u);
		longint unsigned whole;
		longint unsigned r;
		longint unsigned inv_e;
		whole = u >> 30;
		r     = (Q30 << 30) / exp_series(u & (Q30 - 1));
		inv_e = (Q30 << 30) / exp_series(Q30);
		if (whole > 40)
			return 0;
		for (longint unsigned i = 0; i < whole; i++)
			r = (r * inv_e) >> 30;
		return r;
	endfunction

	function automatic void build_knots();
		longint unsigned half_lsb;
		longint unsigned num;
		longint unsigned mid;
		longint unsigned mag;
		longint unsigned e1;
		longint unsigned e2;
		longint unsigned sg;
		longint unsigned th;
		longint          th_q;
		bit              neg;
		half_lsb = 64'd1 << (29 - FRAC_BITS);
		mid      = 64'(8 * SEGMENTS);
		for (int k = 0; k <= SEGMENTS; k++) begin
			num = 64'(16 * k);
			neg = num < mid;
			mag = neg ? ((mid - num) << 30) / 64'(SEGMENTS) : ((num - mid) << 30) / 64'(SEGMENTS);
			e1  = exp_decay(mag);
			sg  = (Q30 << 30) / (Q30 + e1);
			if (neg)
				sg = Q30 - sg;
			sig_knots[k] = longint'((sg + half_lsb) >> (30 - FRAC_BITS));
			// tanh is rounded on its magnitude and mirrored, so the table stays odd
			e2   = exp_decay(2 * mag);
			th   = ((Q30 - e2) << 30) / (Q30 + e2);
			th_q = longint'((th + half_lsb) >> (30 - FRAC_BITS));
			tanh_knots[k] = neg ? -th_q : th_q;
		end
	endfunction

	// Divide with rounding to nearest, halves away from zero; den is positive
	function automatic longint round_div(input longint n, input longint den);
		if (n >= 0)
			return (n + den / 2) / den;
		return -((-n + den / 2) / den);
	endfunction

	function automatic longint curve_value(input bit use_tanh, input longint x);
		longint eight;
		longint span;
		longint p;
		longint seg;
		longint off;
		longint lo;
		longint hi;
		eight = longint'(8) << FRAC_BITS;
		span  = longint'(16) << FRAC_BITS;
		// Saturate outside [-8, 8); only reachable with fewer fraction bits
		if (x < -eight)
			return use_tanh ? tanh_knots[0] : sig_knots[0];
		if (x >= eight)
			return use_tanh ? tanh_knots[SEGMENTS] : sig_knots[SEGMENTS];
		p   = (x + eight) * SEGMENTS;
		seg = p / span;
		if (seg >= SEGMENTS)
			seg = SEGMENTS - 1;
		off = p - seg * span;
		lo  = use_tanh ? tanh_knots[seg] : sig_knots[seg];
		hi  = use_tanh ? tanh_knots[seg+1] : sig_knots[seg+1];
		return round_div(lo * span + (hi - lo) * off, span);
	endfunction

	// Expected output for one element under the given activation
	function automatic grad_result_t activation_result(input act_mode_t mode, input element_t el);
		longint       x;
		longint       y;
		longint       up;
		longint       one;
		longint       term;
		longint       res;
		grad_result_t r;
		x   = longint'(el.x);
		y   = longint'(el.y);
		up  = longint'(el.up);
		one = longint'(Q_ONE);
		if (el.action == ACTION_FORWARD) begin
			case (mode)
				MODE_RELU:    res = x > 0 ? x : 0;
				MODE_SIGMOID: res = curve_value(1'b0, x);
				MODE_TANH:    res = curve_value(1'b1, x);
				default:      res = x;
			endcase
		end else begin
			// Derivative uses y exactly as given, even far outside the curve's range
			case (mode)
				MODE_RELU:    term = x > 0 ? up : 0;
				MODE_SIGMOID: term = round_div(up * (y * (one - y)), one * one);
				MODE_TANH:    term = round_div(up * (one * one - y * y), one * one);
				default:      term = up;
			endcase
			res = longint'(el.acc) + term;
			if (res > 32767)
				res = 32767;
			if (res < -32768)
				res = -32768;
		end
		r.value = res[DATA_BITS-1:0];
		r.last  = el.last;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Random fields
	// ------------------------------------------------------------------

	function automatic logic [15:0] random_word();
		case ($urandom_range(9))
			0:       return 16'h8000;
			1:       return 16'h7fff;
			2, 3:    return 16'(int'($urandom_range(2 * Q_ONE)) - Q_ONE);
			default: return 16'($urandom);
		endcase
	endfunction

	// Inputs near a knot exercise the segment index and the interpolation rounding
	function automatic logic [15:0] random_x();
		int b;
		if ($urandom_range(3) == 0) begin
			b = int'($urandom_range(SEGMENTS - 1)) * SEG_SPAN - 32768
				+ int'($urandom_range(2)) - 1;
			return 16'(b);
		end
		return random_word();
	endfunction

	// Mostly plausible forward outputs, the rest anything at all
	function automatic logic [15:0] random_y(input act_mode_t mode);
		if ($urandom_range(9) < 7) begin
			if (mode == MODE_SIGMOID)
				return 16'($urandom_range(Q_ONE));
			if (mode == MODE_TANH)
				return 16'(int'($urandom_range(2 * Q_ONE)) - Q_ONE);
		end
		return random_word();
	endfunction

	function automatic element_t random_element(input act_mode_t mode);
		element_t el;
		el.action = ($urandom_range(1) == 1) ? ACTION_BACKWARD : ACTION_FORWARD;
		el.x      = random_x();
		el.y      = random_y(mode);
		el.up     = random_word();
		el.acc    = random_word();
		el.last   = ($urandom_range(7) == 0);
		return el;
	endfunction

	// ------------------------------------------------------------------
	// Driving and checking
	// ------------------------------------------------------------------

	task automatic report_mismatch(input string msg);
		if (error_count < PRINT_LIMIT)
			$display("MISMATCH at %0t ns: %s", $time, msg);
		error_count++;
	endtask

	// Hold the element on the slave side until the transaction completes,
	// then queue the result it must produce
	task automatic send_element(input element_t el, input grad_result_t expected);
		while ($urandom_range(99) < sender_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {el.acc, el.up, el.y, el.x};
		s_tuser  <= el.action;
		s_tlast  <= el.last;
		do
			@(posedge clk);
		while (!s_tready);
		expected_results.push_back(expected);
		mode_items[current_mode]++;
	endtask

	// Drain the pipeline, then write act_mode over the configuration channel
	task automatic set_act_mode(input act_mode_t mode);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid    <= 1'b0;
		current_mode  = mode;
	endtask

	// Master side: stall at random and compare every result transaction
	always @(posedge clk) begin
		grad_result_t exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch($sformatf("unexpected result %h", m_tdata));
			end else begin
				exp_r = expected_results.pop_front();
				checked_count++;
				if (m_tdata !== exp_r.value)
					report_mismatch($sformatf("result_value %h, expected %h",
						m_tdata, exp_r.value));
				if (m_tlast !== exp_r.last)
					report_mismatch($sformatf("last_out %b, expected %b",
						m_tlast, exp_r.last));
			end
		end
		m_tready <= ($urandom_range(99) >= receiver_stall_pct);
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TIMEOUT: run did not complete");
		$display("DONE: errors detected");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin
		element_t     el;
		grad_result_t exp_r;
		act_mode_t    mode;

		arst_n             = 1'b0;
		cfg_valid          = 1'b0;
		cfg_data           = '0;
		s_tvalid           = 1'b0;
		s_tdata            = '0;
		s_tuser            = '0;
		s_tlast            = 1'b0;
		error_count        = 0;
		checked_count      = 0;
		mode_items         = '{default: 0};
		current_mode       = MODE_RELU;   // value after reset
		sender_idle_pct    = 13;
		receiver_stall_pct = 80;
		build_knots();

		// mode, action, x, y, upstream, accumulated, last, typed, expected value
		directed_rows = '{
			'{MODE_RELU, ACTION_FORWARD, 16'sh7fff, 16'sh0, 16'sh0, 16'sh0, 1'b0, 1'b1, 16'sh7fff},
			'{MODE_RELU, ACTION_FORWARD, 16'sh8000, 16'sh0, 16'sh0, 16'sh0, 1'b0, 1'b1, 16'sh0},
			'{MODE_RELU, ACTION_FORWARD, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0, 1'b1, 16'sh0},
			'{MODE_RELU, ACTION_FORWARD, 16'sh1, 16'sh0, 16'sh0, 16'sh0, 1'b1, 1'b1, 16'sh1},
			'{MODE_RELU, ACTION_BACKWARD, 16'sh0, 16'sh0, 16'sd100, 16'sd5, 1'b0, 1'b1, 16'sd5},
			'{MODE_RELU, ACTION_BACKWARD, 16'sh1, 16'sh0, 16'sh7fff, 16'sh7fff, 1'b0, 1'b1,
				16'sh7fff},
			'{MODE_RELU, ACTION_BACKWARD, 16'sd5, 16'sh0, 16'sh8000, 16'sh8000, 1'b1, 1'b1,
				16'sh8000},
			'{MODE_SIGMOID, ACTION_FORWARD, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0, 1'b1, 16'sd2048},
			'{MODE_SIGMOID, ACTION_FORWARD, 16'sh8000, 16'sh0, 16'sh0, 16'sh0, 1'b0, 1'b0, 16'sh0},
			'{MODE_SIGMOID, ACTION_FORWARD, 16'sh7fff, 16'sh0, 16'sh0, 16'sh0, 1'b1, 1'b0, 16'sh0},
			'{MODE_SIGMOID, ACTION_BACKWARD, 16'sh0, 16'sd2048, 16'sd4096, 16'sh0, 1'b0, 1'b1,
				16'sd1024},
			'{MODE_SIGMOID, ACTION_BACKWARD, 16'sh0, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0, 1'b0,
				16'sh0},
			'{MODE_SIGMOID, ACTION_BACKWARD, 16'sh0, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b1, 1'b0,
				16'sh0},
			'{MODE_TANH, ACTION_FORWARD, 16'sh0, 16'sh0, 16'sh0, 16'sh0, 1'b0, 1'b1, 16'sh0},
			'{MODE_TANH, ACTION_FORWARD, 16'sh8000, 16'sh0, 16'sh0, 16'sh0, 1'b0, 1'b0, 16'sh0},
			'{MODE_TANH, ACTION_FORWARD, 16'sh7fff, 16'sh0, 16'sh0, 16'sh0, 1'b0, 1'b0, 16'sh0},
			'{MODE_TANH, ACTION_BACKWARD, 16'sh0, 16'sh0, 16'sd4096, 16'sd100, 1'b0, 1'b1,
				16'sd4196},
			'{MODE_TANH, ACTION_BACKWARD, 16'sh0, 16'sh8000, 16'sh8000, 16'sh0, 1'b0, 1'b0, 16'sh0},
			'{MODE_TANH, ACTION_BACKWARD, 16'sh0, 16'sd4096, 16'sd1234, -16'sd1234, 1'b1, 1'b1,
				-16'sd1234},
			'{MODE_IDENTITY, ACTION_FORWARD, 16'sh8000, 16'sh0, 16'sh0, 16'sh0, 1'b0, 1'b1,
				16'sh8000},
			'{MODE_IDENTITY, ACTION_FORWARD, 16'sd12345, 16'sh0, 16'sh0, 16'sh0, 1'b0, 1'b1,
				16'sd12345},
			'{MODE_IDENTITY, ACTION_BACKWARD, 16'sh0, 16'sh0, 16'sh7fff, 16'sh7fff, 1'b0, 1'b1,
				16'sh7fff},
			'{MODE_IDENTITY, ACTION_BACKWARD, 16'sh0, 16'sh0, 16'sh8000, -16'sd1, 1'b1, 1'b1,
				16'sh8000}
		};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part: the first rows run on the mode left by reset
		foreach (directed_rows[i]) begin
			if (directed_rows[i].mode != current_mode)
				set_act_mode(directed_rows[i].mode);
			el.action = directed_rows[i].action;
			el.x      = directed_rows[i].x;
			el.y      = directed_rows[i].y;
			el.up     = directed_rows[i].up;
			el.acc    = directed_rows[i].acc;
			el.last   = directed_rows[i].last;
			if (directed_rows[i].typed) begin
				exp_r.value = directed_rows[i].value;
				exp_r.last  = directed_rows[i].last;
			end else begin
				exp_r = activation_result(current_mode, el);
			end
			send_element(el, exp_r);
		end

		// Random part: every mode under each idling profile, order rotated per profile
		for (int prof = 0; prof < 3; prof++) begin
			case (prof)
				0: begin
					sender_idle_pct    = 13;
					receiver_stall_pct = 80;
				end
				1: begin
					sender_idle_pct    = 80;
					receiver_stall_pct = 13;
				end
				default: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
			endcase
			for (int mi = 0; mi < 4; mi++) begin
				mode = act_mode_t'((mi + prof) % 4);
				set_act_mode(mode);
				repeat (RANDOM_PER_SET) begin
					el = random_element(current_mode);
					send_element(el, activation_result(current_mode, el));
				end
			end
		end

		// Drain, then give the pipeline time to show any stray result
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (2 * PIPE_LATENCY) @(posedge clk);

		$display("Checked %0d results: relu %0d, sigmoid %0d, tanh %0d, identity %0d elements,",
			checked_count, mode_items[MODE_RELU], mode_items[MODE_SIGMOID],
			mode_items[MODE_TANH], mode_items[MODE_IDENTITY]);
		$display("forward and backward, under three source/sink idling profiles; %0d mismatches",
			error_count);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

### filelist.f
hw/rtl/afb_pkg.sv
hw/rtl/afb_seg_lookup.sv
hw/rtl/activation_forward_backward_unit.sv
hw/rtl/afb_checker.sv
tb/sv/tb_activation_forward_backward_unit.sv
